>>> rtl/core/psu_pkg.sv
`timescale 1ns / 1ps

package psu_pkg;

    localparam int PERIOD_W  = 12;
    localparam int SHIFT_W   = 4;
    localparam int VOLUME_W  = 4;
    localparam int STEP_W    = 4;
    localparam int RATE_W    = 6;
    localparam int ACC_W     = 8;
    localparam int REACT_W   = 3;
    localparam int SAW_LVL_W = 5;
    localparam int PULSES    = 2;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // blocks
    localparam logic [1:0] BLOCK_PULSE_A = 2'd0;
    localparam logic [1:0] BLOCK_PULSE_B = 2'd1;
    localparam logic [1:0] BLOCK_SAW     = 2'd2;
    localparam logic [1:0] BLOCK_NONE    = 2'd3;

    // registers within a block
    localparam logic [1:0] REG_CTRL      = 2'd0;
    localparam logic [1:0] REG_PERIOD_LO = 2'd1;
    localparam logic [1:0] REG_PERIOD_HI = 2'd2;
    localparam logic [1:0] REG_GLOBAL    = 2'd3;

    localparam logic [RATE_W-1:0]  RATE_MASK    = 6'h3F;
    localparam int                 ENABLE_BIT   = 7;
    localparam int                 HALT_BIT     = 0;
    localparam int                 SHIFT16_BIT  = 1;
    localparam int                 SHIFT256_BIT = 2;
    localparam logic [SHIFT_W-1:0] SHIFT_NONE   = 4'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_16X    = 4'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_256X   = 4'd8;
    localparam logic [STEP_W-1:0]  STEP_RESTART = 4'd15;
    localparam logic [REACT_W-1:0] SAW_ADDS     = 3'd6;

    typedef struct packed {
        logic       req_type;
        logic [1:0] block_sel;
        logic [1:0] reg_sel;
        logic [7:0] data;
    } psu_req_t;

    typedef struct packed {
        logic [VOLUME_W-1:0]  pulse_a_level;
        logic [VOLUME_W-1:0]  pulse_b_level;
        logic [SAW_LVL_W-1:0] saw_level;
    } psu_res_t;

    function automatic logic [PERIOD_W-1:0] eff_period(
        input logic [PERIOD_W-1:0] period,
        input logic [SHIFT_W-1:0]  shift
    );
        return period >> shift;
    endfunction

    // divider is pulled down to the effective period when it exceeds it
    function automatic logic [PERIOD_W-1:0] clamp_div(
        input logic [PERIOD_W-1:0] div,
        input logic [PERIOD_W-1:0] period,
        input logic [SHIFT_W-1:0]  shift
    );
        logic [PERIOD_W-1:0] lim;
        lim = eff_period(period, shift);
        return (div > lim) ? lim : div;
    endfunction

endpackage

>>> rtl/core/pulse_saw_sound_unit.sv
`timescale 1ns / 1ps

// Two pulse channels and one sawtooth channel driven by a stream of request
// words, each either a register write or one chip clock tick. Every accepted
// request yields exactly one result word with the three channel levels as
// they stand after that request. While the result side keeps up, a request
// is accepted in every cycle, and its result is in the output register in the
// cycle after acceptance. State update and level decode are one combinational
// pass from the request port to the state and result registers. A one-word
// skid entry behind the result register takes one more request while the
// result side is stalled; after that req_stall holds the request side until
// the output register is taken.
module pulse_saw_sound_unit
    import psu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  psu_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output psu_res_t res
);

    logic [7:0]          pulse_ctrl_reg    [PULSES];
    logic [7:0]          pulse_ctrl_next   [PULSES];
    logic [PERIOD_W-1:0] pulse_period_reg  [PULSES];
    logic [PERIOD_W-1:0] pulse_period_next [PULSES];
    logic [PERIOD_W-1:0] pulse_div_reg     [PULSES];
    logic [PERIOD_W-1:0] pulse_div_next    [PULSES];
    logic [STEP_W-1:0]   pulse_step_reg    [PULSES];
    logic [STEP_W-1:0]   pulse_step_next   [PULSES];
    logic                pulse_on_reg      [PULSES];
    logic                pulse_on_next     [PULSES];

    logic [RATE_W-1:0]   ramp_rate_reg,      ramp_rate_next;
    logic [PERIOD_W-1:0] ramp_period_reg,    ramp_period_next;
    logic [PERIOD_W-1:0] ramp_div_reg,       ramp_div_next;
    logic [ACC_W-1:0]    ramp_acc_reg,       ramp_acc_next;
    logic [REACT_W-1:0]  ramp_reactions_reg, ramp_reactions_next;
    logic                ramp_half_reg,      ramp_half_next;
    logic                ramp_on_reg,        ramp_on_next;
    logic                halted_reg,         halted_next;
    logic [SHIFT_W-1:0]  shift_reg,          shift_next;

    logic                pulse_expire [PULSES];
    logic                ramp_expire;
    logic [VOLUME_W-1:0] pulse_level  [PULSES];

    psu_res_t result;
    psu_res_t out_reg;
    psu_res_t skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;
    logic     accept;
    logic     out_take;

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !res_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // divider expiry on a tick: the incremented count passes the effective period
    always_comb
    begin
        for (int ch = 0; ch < PULSES; ch++)
        begin
            pulse_expire[ch] = ({1'b0, pulse_div_reg[ch]} + 13'd1) >
                               {1'b0, eff_period(pulse_period_reg[ch], shift_reg)};
        end
        ramp_expire = ({1'b0, ramp_div_reg} + 13'd1) >
                      {1'b0, eff_period(ramp_period_reg, shift_reg)};
    end

    always_comb
    begin
        for (int ch = 0; ch < PULSES; ch++)
        begin
            pulse_ctrl_next[ch]   = pulse_ctrl_reg[ch];
            pulse_period_next[ch] = pulse_period_reg[ch];
            pulse_div_next[ch]    = pulse_div_reg[ch];
            pulse_step_next[ch]   = pulse_step_reg[ch];
            pulse_on_next[ch]     = pulse_on_reg[ch];
        end
        ramp_rate_next      = ramp_rate_reg;
        ramp_period_next    = ramp_period_reg;
        ramp_div_next       = ramp_div_reg;
        ramp_acc_next       = ramp_acc_reg;
        ramp_reactions_next = ramp_reactions_reg;
        ramp_half_next      = ramp_half_reg;
        ramp_on_next        = ramp_on_reg;
        halted_next         = halted_reg;
        shift_next          = shift_reg;

        if (accept)
        begin
            if (req.req_type == REQ_WRITE)
            begin
                if (req.block_sel == BLOCK_PULSE_A && req.reg_sel == REG_GLOBAL)
                begin
                    halted_next = req.data[HALT_BIT];
                    if (req.data[SHIFT256_BIT])
                        shift_next = SHIFT_256X;
                    else if (req.data[SHIFT16_BIT])
                        shift_next = SHIFT_16X;
                    else
                        shift_next = SHIFT_NONE;
                    for (int ch = 0; ch < PULSES; ch++)
                    begin
                        pulse_div_next[ch] = clamp_div(pulse_div_reg[ch],
                                                       pulse_period_reg[ch], shift_next);
                    end
                    ramp_div_next = clamp_div(ramp_div_reg, ramp_period_reg, shift_next);
                end
                else if (req.block_sel == BLOCK_PULSE_A || req.block_sel == BLOCK_PULSE_B)
                begin
                    for (int ch = 0; ch < PULSES; ch++)
                    begin
                        if (req.block_sel == 2'(ch))
                        begin
                            unique case (req.reg_sel)
                                REG_CTRL:
                                begin
                                    pulse_ctrl_next[ch] = req.data;
                                end
                                REG_PERIOD_LO:
                                begin
                                    pulse_period_next[ch] = {pulse_period_reg[ch][11:8],
                                                             req.data};
                                    pulse_div_next[ch] = clamp_div(pulse_div_reg[ch],
                                                                   pulse_period_next[ch],
                                                                   shift_reg);
                                end
                                REG_PERIOD_HI:
                                begin
                                    pulse_period_next[ch] = {req.data[3:0],
                                                             pulse_period_reg[ch][7:0]};
                                    pulse_div_next[ch] = clamp_div(pulse_div_reg[ch],
                                                                   pulse_period_next[ch],
                                                                   shift_reg);
                                    if (!pulse_on_reg[ch])
                                        pulse_step_next[ch] = STEP_RESTART;
                                    pulse_on_next[ch] = req.data[ENABLE_BIT];
                                end
                                REG_GLOBAL:
                                begin
                                    // only block 0 owns the global register
                                end
                            endcase
                        end
                    end
                end
                else if (req.block_sel == BLOCK_SAW)
                begin
                    unique case (req.reg_sel)
                        REG_CTRL:
                        begin
                            ramp_rate_next = req.data[RATE_W-1:0] & RATE_MASK;
                        end
                        REG_PERIOD_LO:
                        begin
                            ramp_period_next = {ramp_period_reg[11:8], req.data};
                            ramp_div_next = clamp_div(ramp_div_reg, ramp_period_next,
                                                      shift_reg);
                        end
                        REG_PERIOD_HI:
                        begin
                            ramp_period_next = {req.data[3:0], ramp_period_reg[7:0]};
                            ramp_div_next = clamp_div(ramp_div_reg, ramp_period_next,
                                                      shift_reg);
                            if (!ramp_on_reg)
                            begin
                                ramp_acc_next       = '0;
                                ramp_reactions_next = '0;
                                ramp_half_next      = 1'b0;
                            end
                            ramp_on_next = req.data[ENABLE_BIT];
                        end
                        REG_GLOBAL:
                        begin
                        end
                    endcase
                end
            end
            else if (!halted_reg)
            begin
                for (int ch = 0; ch < PULSES; ch++)
                begin
                    if (pulse_on_reg[ch])
                    begin
                        if (pulse_expire[ch])
                        begin
                            pulse_div_next[ch]  = '0;
                            pulse_step_next[ch] = pulse_step_reg[ch] - 4'd1;
                        end
                        else
                        begin
                            pulse_div_next[ch] = pulse_div_reg[ch] + 12'd1;
                        end
                    end
                end
                if (ramp_on_reg)
                begin
                    if (ramp_expire)
                    begin
                        ramp_div_next  = '0;
                        ramp_half_next = !ramp_half_reg;
                        // accumulator reacts on every second expiry
                        if (ramp_half_reg)
                        begin
                            if (ramp_reactions_reg >= SAW_ADDS)
                            begin
                                ramp_acc_next       = '0;
                                ramp_reactions_next = '0;
                            end
                            else
                            begin
                                ramp_acc_next       = ramp_acc_reg + ACC_W'(ramp_rate_reg);
                                ramp_reactions_next = ramp_reactions_reg + 3'd1;
                            end
                        end
                    end
                    else
                    begin
                        ramp_div_next = ramp_div_reg + 12'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < PULSES; ch++)
        begin
            if (pulse_on_next[ch] && (pulse_ctrl_next[ch][7] ||
                pulse_step_next[ch] <= {1'b0, pulse_ctrl_next[ch][6:4]}))
                pulse_level[ch] = pulse_ctrl_next[ch][3:0];
            else
                pulse_level[ch] = '0;
        end
        result.pulse_a_level = pulse_level[0];
        result.pulse_b_level = pulse_level[1];
        result.saw_level     = ramp_on_next ? ramp_acc_next[7:3] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < PULSES; ch++)
            begin
                pulse_ctrl_reg[ch]   <= '0;
                pulse_period_reg[ch] <= '0;
                pulse_div_reg[ch]    <= '0;
                pulse_step_reg[ch]   <= '0;
                pulse_on_reg[ch]     <= 1'b0;
            end
            ramp_rate_reg      <= '0;
            ramp_period_reg    <= '0;
            ramp_div_reg       <= '0;
            ramp_acc_reg       <= '0;
            ramp_reactions_reg <= '0;
            ramp_half_reg      <= 1'b0;
            ramp_on_reg        <= 1'b0;
            halted_reg         <= 1'b0;
            shift_reg          <= '0;
        end
        else
        begin
            for (int ch = 0; ch < PULSES; ch++)
            begin
                pulse_ctrl_reg[ch]   <= pulse_ctrl_next[ch];
                pulse_period_reg[ch] <= pulse_period_next[ch];
                pulse_div_reg[ch]    <= pulse_div_next[ch];
                pulse_step_reg[ch]   <= pulse_step_next[ch];
                pulse_on_reg[ch]     <= pulse_on_next[ch];
            end
            ramp_rate_reg      <= ramp_rate_next;
            ramp_period_reg    <= ramp_period_next;
            ramp_div_reg       <= ramp_div_next;
            ramp_acc_reg       <= ramp_acc_next;
            ramp_reactions_reg <= ramp_reactions_next;
            ramp_half_reg      <= ramp_half_next;
            ramp_on_reg        <= ramp_on_next;
            halted_reg         <= halted_next;
            shift_reg          <= shift_next;
        end
    end

    // result register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

endmodule
